// ===== rtl/lph_pkg.sv =====
`default_nettype none
package lph_pkg;

  // Fixed field widths
  localparam int SIZE_W     = 11;  // table_size register
  localparam int SUM_W      = 11;  // byte sum of up to eight key bytes
  localparam int STEP_W     = $clog2(SUM_W);
  localparam int VALUE_W    = 16;
  localparam int KEY_FULL_W = 64;
  localparam int BUCKET_W   = 10;
  localparam int STATUS_W   = 2;
  localparam int IN_DATA_W  = KEY_FULL_W + VALUE_W;  // 80 bits, whole bytes
  localparam int OUT_DATA_W = 16;

  // Defaults for the top level parameters
  localparam int DEF_TABLE_DEPTH = 1024;
  localparam int DEF_KEY_BYTES   = 8;

  // Reset value of table_size
  localparam logic [SIZE_W-1:0] TABLE_SIZE_RESET = 11'd1021;

  // Opcodes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;

  // Controller states
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_ISSUE,
    S_PROBE,
    S_FINISH
  } state_t;

endpackage
`default_nettype wire

// ===== rtl/linear_probe_hash_table.sv =====
`default_nettype none
// Open-addressing hash table with linear probing, keys and values in block RAM.
//
// Input channel (s_*): one beat per request. s_tuser is the opcode (insert or
// search); s_tdata carries the key and, for insert, a nonzero value.
// Output channel (m_*): one beat per request with the status in m_tuser and
// the slot index in m_tdata.
// Config channel (cfg_*): writes table_size; always ready, write it only
// while no request is in flight.
//
// Timing: after a request beat the home bucket is reduced modulo the table
// size by a restoring remainder unit, one bit a cycle. Then S_ISSUE issues
// the first RAM read, and each probed slot takes one read on the single RAM
// read port. The result is loaded in S_FINISH and the next request is taken
// in the cycle after that, so one request is finished before the next is taken.
// Reset: a clearing pass writes every slot empty, during which s_tready
// stays low. Config writes are taken throughout.
// Stall: the result waits in the output register; a new request is still
// accepted and processed, and only its result load waits for the slot.
module linear_probe_hash_table #(
  parameter int TABLE_DEPTH = lph_pkg::DEF_TABLE_DEPTH,
  parameter int KEY_BYTES   = lph_pkg::DEF_KEY_BYTES
) (
  input  wire                                clk,
  input  wire                                rst,
  // config write
  input  wire                                cfg_valid,
  output logic                               cfg_ready,
  input  wire  [lph_pkg::SIZE_W-1:0]         cfg_data,    // table_size
  // request stream
  input  wire                                s_tvalid,
  output logic                               s_tready,
  input  wire  [lph_pkg::IN_DATA_W-1:0]      s_tdata,     // key_chars[63:0], entry_value[79:64]
  input  wire                                s_tuser,     // opcode
  // result stream
  output logic                               m_tvalid,
  input  wire                                m_tready,
  output logic [lph_pkg::OUT_DATA_W-1:0]     m_tdata,     // bucket[9:0], zero pad[15:10]
  output logic [lph_pkg::STATUS_W-1:0]       m_tuser      // status
);
  import lph_pkg::*;

  localparam int ADDR_W = $clog2(TABLE_DEPTH);
  localparam int KEY_W  = 8 * KEY_BYTES;
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(TABLE_DEPTH - 1);

  // Slot memories
  logic [KEY_W-1:0]   slot_keys   [TABLE_DEPTH];
  logic [VALUE_W-1:0] slot_values [TABLE_DEPTH];

  logic               rd_en;
  logic [ADDR_W-1:0]  rd_addr;
  logic [KEY_W-1:0]   rd_key;
  logic [VALUE_W-1:0] rd_val;
  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  logic [KEY_W-1:0]   wr_key;
  logic [VALUE_W-1:0] wr_val;

  // Control and working registers
  state_t              state, state_next;
  logic [SIZE_W-1:0]   table_size;
  logic [ADDR_W-1:0]   clr_addr, clr_addr_next;
  logic                op_q, op_q_next;
  logic [KEY_W-1:0]    key_q, key_q_next;
  logic [VALUE_W-1:0]  val_q, val_q_next;
  logic [SIZE_W-1:0]   n_q, n_q_next;
  logic [SUM_W-1:0]    sum_q, sum_q_next;
  logic [SIZE_W-1:0]   rem_q, rem_q_next;
  logic [STEP_W-1:0]   step_q, step_q_next;
  logic [SIZE_W-1:0]   b_q, b_q_next;
  logic [SIZE_W-1:0]   cnt_q, cnt_q_next;
  logic [STATUS_W-1:0] res_status, res_status_next;
  logic [BUCKET_W-1:0] res_bucket, res_bucket_next;
  logic                out_valid, out_valid_next;
  logic [STATUS_W-1:0] out_status, out_status_next;
  logic [BUCKET_W-1:0] out_bucket, out_bucket_next;

  // Combinational helpers
  logic [SIZE_W-1:0]   n_eff;
  logic [SUM_W-1:0]    in_sum;
  logic [SIZE_W:0]     rem_shift;
  logic [SIZE_W-1:0]   rem_new;
  logic [SIZE_W:0]     b_inc;
  logic [SIZE_W:0]     cnt_inc;
  logic                slot_empty;
  logic                key_hit;

  assign cfg_ready = 1'b1;
  assign m_tvalid  = out_valid;
  assign m_tuser   = out_status;
  assign m_tdata   = {{(OUT_DATA_W - BUCKET_W){1'b0}}, out_bucket};

  // Effective table size: zero acts as one, clamp to the memory depth
  always_comb begin
    if (table_size == '0) begin
      n_eff = SIZE_W'(1);
    end else if (32'(table_size) > 32'(TABLE_DEPTH)) begin
      n_eff = SIZE_W'(TABLE_DEPTH);
    end else begin
      n_eff = table_size;
    end
  end

  // Byte sum of the key bytes in use
  always_comb begin
    in_sum = '0;
    for (int i = 0; i < KEY_BYTES; i++) begin
      in_sum = in_sum + SUM_W'(s_tdata[8*i +: 8]);
    end
  end

  // One restoring remainder step
  assign rem_shift = {rem_q, sum_q[SUM_W-1]};
  assign rem_new   = (rem_shift >= {1'b0, n_q}) ? SIZE_W'(rem_shift - {1'b0, n_q})
                                                : SIZE_W'(rem_shift);

  // Probe bookkeeping
  assign b_inc      = {1'b0, b_q} + (SIZE_W + 1)'(1);
  assign cnt_inc    = {1'b0, cnt_q} + (SIZE_W + 1)'(1);
  assign slot_empty = (rd_val == '0);
  assign key_hit    = (rd_key == key_q);

  // Memory ports
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_keys[wr_addr]   <= wr_key;
      slot_values[wr_addr] <= wr_val;
    end
    if (rd_en) begin
      rd_key <= slot_keys[rd_addr];
      rd_val <= slot_values[rd_addr];
    end
  end

  // Config register
  always_ff @(posedge clk) begin
    if (rst) begin
      table_size <= TABLE_SIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      table_size <= cfg_data;
    end
  end

  // State and registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      clr_addr  <= clr_addr_next;
      out_valid <= out_valid_next;
    end
    op_q       <= op_q_next;
    key_q      <= key_q_next;
    val_q      <= val_q_next;
    n_q        <= n_q_next;
    sum_q      <= sum_q_next;
    rem_q      <= rem_q_next;
    step_q     <= step_q_next;
    b_q        <= b_q_next;
    cnt_q      <= cnt_q_next;
    res_status <= res_status_next;
    res_bucket <= res_bucket_next;
    out_status <= out_status_next;
    out_bucket <= out_bucket_next;
  end

  // Next state and datapath control
  always_comb begin
    state_next      = state;
    clr_addr_next   = clr_addr;
    op_q_next       = op_q;
    key_q_next      = key_q;
    val_q_next      = val_q;
    n_q_next        = n_q;
    sum_q_next      = sum_q;
    rem_q_next      = rem_q;
    step_q_next     = step_q;
    b_q_next        = b_q;
    cnt_q_next      = cnt_q;
    res_status_next = res_status;
    res_bucket_next = res_bucket;
    out_status_next = out_status;
    out_bucket_next = out_bucket;
    out_valid_next  = out_valid;
    s_tready        = 1'b0;
    rd_en           = 1'b0;
    rd_addr         = ADDR_W'(b_q);
    wr_en           = 1'b0;
    wr_addr         = ADDR_W'(b_q);
    wr_key          = key_q;
    wr_val          = val_q;

    // output beat taken
    if (m_tready) begin
      out_valid_next = 1'b0;
    end

    case (state)
      S_CLEAR: begin
        wr_en         = 1'b1;
        wr_addr       = clr_addr;
        wr_key        = '0;
        wr_val        = '0;
        clr_addr_next = clr_addr + ADDR_W'(1);
        if (clr_addr == LAST_ADDR) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          op_q_next   = s_tuser;
          key_q_next  = s_tdata[KEY_W-1:0];
          val_q_next  = s_tdata[KEY_FULL_W +: VALUE_W];
          n_q_next    = n_eff;
          sum_q_next  = in_sum;
          rem_q_next  = '0;
          step_q_next = STEP_W'(SUM_W - 1);
          if (s_tuser == OP_INSERT && s_tdata[KEY_FULL_W +: VALUE_W] == '0) begin
            res_status_next = STATUS_NOT_FOUND;
            res_bucket_next = '0;
            state_next      = S_FINISH;
          end else begin
            state_next = S_HASH;
          end
        end
      end
      S_HASH: begin
        rem_q_next  = rem_new;
        sum_q_next  = {sum_q[SUM_W-2:0], 1'b0};
        step_q_next = step_q - STEP_W'(1);
        if (step_q == '0) begin
          b_q_next   = rem_new;
          state_next = S_ISSUE;
        end
      end
      S_ISSUE: begin
        rd_en      = 1'b1;
        cnt_q_next = '0;
        state_next = S_PROBE;
      end
      S_PROBE: begin
        if (op_q == OP_INSERT && slot_empty) begin
          wr_en           = 1'b1;
          res_status_next = STATUS_DONE;
          res_bucket_next = BUCKET_W'(b_q);
          state_next      = S_FINISH;
        end else if (op_q == OP_SEARCH && slot_empty) begin
          res_status_next = STATUS_NOT_FOUND;
          res_bucket_next = '0;
          state_next      = S_FINISH;
        end else if (op_q == OP_SEARCH && key_hit) begin
          res_status_next = STATUS_DONE;
          res_bucket_next = BUCKET_W'(b_q);
          state_next      = S_FINISH;
        end else if (cnt_inc == {1'b0, n_q}) begin
          // every slot visited
          res_status_next = (op_q == OP_INSERT) ? STATUS_FULL : STATUS_NOT_FOUND;
          res_bucket_next = '0;
          state_next      = S_FINISH;
        end else begin
          b_q_next   = (b_inc == {1'b0, n_q}) ? '0 : b_inc[SIZE_W-1:0];
          cnt_q_next = cnt_inc[SIZE_W-1:0];
          rd_en      = 1'b1;
          rd_addr    = ADDR_W'(b_q_next);
        end
      end
      S_FINISH: begin
        // load the output register once it is free
        if (!out_valid || m_tready) begin
          out_valid_next  = 1'b1;
          out_status_next = res_status;
          out_bucket_next = res_bucket;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire
